### rtl/mpmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-pattern match counter package
// Shared field widths, mode and status codes, and the queued item type.
// ----------------------------------------------------------------------------
package mpmc_pkg;

    localparam int MODE_W   = 3;
    localparam int SYMBOL_W = 5;
    localparam int QID_W    = 8;
    localparam int PID_W    = 8;
    localparam int MATCH_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PATTERN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BUILD   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TEXT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FINISH  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd3;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_PATTERN,
        OP_BUILD,
        OP_TEXT,
        OP_FINISH,
        OP_READ,
        OP_BAD
    } op_t;

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_SCAN,
        PH_DONE
    } phase_t;

    typedef struct packed {
        op_t                 op;
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic [QID_W-1:0]    query_id;
    } item_t;

endpackage
`default_nettype wire

### rtl/mpmc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/mpmc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts input beats and classifies each into an operation for the queue.
// ----------------------------------------------------------------------------
module mpmc_front
    import mpmc_pkg::*;
#(
    parameter int ALPHABET = 26
) (
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [SYMBOL_W-1:0] symbol,
    input  wire logic                last,
    input  wire logic [QID_W-1:0]    query_id,
    input  wire logic                q_full,
    output logic                     q_push,
    output item_t                    q_item
);

    logic sym_ok;

    assign sym_ok   = (32'(symbol) < ALPHABET);
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.symbol   = symbol;
        q_item.last     = last;
        q_item.query_id = query_id;
        unique case (mode)
            MODE_CLEAR:   q_item.op = OP_CLEAR;
            MODE_PATTERN: q_item.op = sym_ok ? OP_PATTERN : OP_BAD;
            MODE_BUILD:   q_item.op = OP_BUILD;
            MODE_TEXT:    q_item.op = sym_ok ? OP_TEXT : OP_BAD;
            MODE_FINISH:  q_item.op = OP_FINISH;
            MODE_READ:    q_item.op = OP_READ;
            default:      q_item.op = OP_BAD;
        endcase
    end

endmodule
`default_nettype wire

### rtl/mpmc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Item queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mpmc_queue
    import mpmc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       valid,
    output item_t      item
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_pop;

    assign full   = (count_reg == 2'd2);
    assign valid  = (count_reg != 2'd0);
    assign item   = slot_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### rtl/mpmc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Sequencer that runs each operation over the trie, link and count memories.
// ----------------------------------------------------------------------------
module mpmc_back
    import mpmc_pkg::*;
#(
    parameter int MAX_NODES    = 1024,
    parameter int MAX_PATTERNS = 255,
    parameter int ALPHABET     = 26,
    parameter int COUNT_BITS   = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  item_t                    q_item,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [PID_W-1:0]         pattern_id,
    output logic [MATCH_W-1:0]       match_count,
    output logic [STATUS_W-1:0]      status
);

    localparam int NODE_W      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int TAIL_W      = $clog2(MAX_NODES + 1);
    localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
    localparam int SYM_IW      = $clog2(ALPHABET);
    localparam int PIDS_W      = $clog2(MAX_PATTERNS + 1);
    localparam int PAT_AW      = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [25:0] {
        S_INIT       = 26'd1 << 0,
        S_IDLE       = 26'd1 << 1,
        S_DONE       = 26'd1 << 2,
        S_P_RD       = 26'd1 << 3,
        S_P_CHK      = 26'd1 << 4,
        S_P_CLR      = 26'd1 << 5,
        S_P_LAST     = 26'd1 << 6,
        S_P_ID       = 26'd1 << 7,
        S_T_RD       = 26'd1 << 8,
        S_T_HIT      = 26'd1 << 9,
        S_T_WR       = 26'd1 << 10,
        S_B_ROOT_RD  = 26'd1 << 11,
        S_B_ROOT_CHK = 26'd1 << 12,
        S_B_POP      = 26'd1 << 13,
        S_B_FAIL     = 26'd1 << 14,
        S_B_GETF     = 26'd1 << 15,
        S_B_RDU      = 26'd1 << 16,
        S_B_RDF      = 26'd1 << 17,
        S_B_WR       = 26'd1 << 18,
        S_A_BFS      = 26'd1 << 19,
        S_A_NODE     = 26'd1 << 20,
        S_A_TGT      = 26'd1 << 21,
        S_A_WR       = 26'd1 << 22,
        S_R_PN       = 26'd1 << 23,
        S_R_HIT      = 26'd1 << 24,
        S_R_OUT      = 26'd1 << 25
    } state_t;

    function automatic logic [CHILD_AW-1:0] child_addr(
        input logic [NODE_W-1:0]   node,
        input logic [CHILD_AW-1:0] sym
    );
        child_addr = CHILD_AW'(node) * CHILD_AW'(ALPHABET) + sym;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [NODE_W-1:0]     highest_reg, highest_next;
    logic [PIDS_W-1:0]     total_reg, total_next;
    logic [NODE_W-1:0]     cur_reg, cur_next;
    logic                  dropped_reg, dropped_next;
    logic                  init_reply_reg, init_reply_next;
    logic [SYM_IW-1:0]     idx_reg, idx_next;
    logic [TAIL_W-1:0]     head_reg, head_next;
    logic [TAIL_W-1:0]     tail_reg, tail_next;
    logic [NODE_W-1:0]     k_reg, k_next;
    logic                  out_valid_reg, out_valid_next;

    item_t                 item_reg, item_next;
    logic [NODE_W-1:0]     u_reg, u_next;
    logic [NODE_W-1:0]     f_reg, f_next;
    logic [NODE_W-1:0]     v_reg, v_next;
    logic [COUNT_BITS-1:0] h_reg, h_next;
    logic [PIDS_W-1:0]     res_id_reg, res_id_next;
    logic [COUNT_BITS-1:0] res_count_reg, res_count_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [PIDS_W-1:0]     out_id_reg, out_id_next;
    logic [COUNT_BITS-1:0] out_count_reg, out_count_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    logic                  child_we;
    logic [CHILD_AW-1:0]   child_waddr, child_raddr;
    logic [NODE_W-1:0]     child_wdata, child_rdata;
    logic                  fail_we;
    logic [NODE_W-1:0]     fail_waddr, fail_raddr, fail_wdata, fail_rdata;
    logic                  npat_we;
    logic [NODE_W-1:0]     npat_waddr, npat_raddr;
    logic [PIDS_W-1:0]     npat_wdata, npat_rdata;
    logic                  hit_we;
    logic [NODE_W-1:0]     hit_waddr, hit_raddr;
    logic [COUNT_BITS-1:0] hit_wdata, hit_rdata;
    logic                  bfs_we;
    logic [NODE_W-1:0]     bfs_waddr, bfs_raddr, bfs_wdata, bfs_rdata;
    logic                  pnode_we;
    logic [PAT_AW-1:0]     pnode_waddr, pnode_raddr;
    logic [NODE_W-1:0]     pnode_wdata, pnode_rdata;

    logic                  out_free;
    logic [CHILD_AW-1:0]   item_sym;
    logic [CHILD_AW-1:0]   idx_sym;

    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign pattern_id  = PID_W'(out_id_reg);
    assign match_count = MATCH_W'(out_count_reg);
    assign status      = out_status_reg;
    assign q_pop       = (state_reg == S_IDLE) && q_valid;
    assign item_sym    = CHILD_AW'(item_reg.symbol);
    assign idx_sym     = CHILD_AW'(idx_reg);

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        highest_next    = highest_reg;
        total_next      = total_reg;
        cur_next        = cur_reg;
        dropped_next    = dropped_reg;
        init_reply_next = init_reply_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg && out_stall;
        item_next       = item_reg;
        u_next          = u_reg;
        f_next          = f_reg;
        v_next          = v_reg;
        h_next          = h_reg;
        res_id_next     = res_id_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        out_id_next     = out_id_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        child_we    = 1'b0;
        child_waddr = '0;
        child_wdata = '0;
        child_raddr = '0;
        fail_we     = 1'b0;
        fail_waddr  = '0;
        fail_wdata  = '0;
        fail_raddr  = '0;
        npat_we     = 1'b0;
        npat_waddr  = '0;
        npat_wdata  = '0;
        npat_raddr  = '0;
        hit_we      = 1'b0;
        hit_waddr   = '0;
        hit_wdata   = '0;
        hit_raddr   = '0;
        bfs_we      = 1'b0;
        bfs_waddr   = '0;
        bfs_wdata   = '0;
        bfs_raddr   = '0;
        pnode_we    = 1'b0;
        pnode_waddr = '0;
        pnode_wdata = '0;
        pnode_raddr = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // Clear the root row and the root's own entries.
                child_we    = 1'b1;
                child_waddr = child_addr('0, idx_sym);
                npat_we     = 1'b1;
                hit_we      = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == SYM_IW'(ALPHABET - 1))
                begin
                    idx_next   = '0;
                    state_next = init_reply_reg ? S_DONE : S_IDLE;
                end
            end

            S_IDLE:
            begin
                res_id_next     = '0;
                res_count_next  = '0;
                res_status_next = ST_OK;
                if (q_valid)
                begin
                    item_next = q_item;
                    unique case (q_item.op)
                        OP_CLEAR:
                        begin
                            phase_next      = PH_LOAD;
                            highest_next    = '0;
                            total_next      = '0;
                            cur_next        = '0;
                            dropped_next    = 1'b0;
                            init_reply_next = 1'b1;
                            idx_next        = '0;
                            state_next      = S_INIT;
                        end
                        OP_PATTERN:
                        begin
                            if (phase_reg != PH_LOAD)
                            begin
                                res_status_next = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else if (dropped_reg)
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_P_LAST;
                            end
                            else
                            begin
                                state_next = S_P_RD;
                            end
                        end
                        OP_BUILD:
                        begin
                            if (phase_reg != PH_LOAD)
                            begin
                                res_status_next = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                cur_next     = '0;
                                dropped_next = 1'b0;
                                idx_next     = '0;
                                head_next    = '0;
                                tail_next    = '0;
                                state_next   = S_B_ROOT_RD;
                            end
                        end
                        OP_TEXT:
                        begin
                            if (phase_reg != PH_SCAN)
                            begin
                                res_status_next = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_T_RD;
                            end
                        end
                        OP_FINISH:
                        begin
                            if (phase_reg != PH_SCAN)
                            begin
                                res_status_next = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                k_next     = highest_reg;
                                state_next = S_A_BFS;
                            end
                        end
                        OP_READ:
                        begin
                            if (phase_reg != PH_DONE || q_item.query_id == '0 ||
                                32'(q_item.query_id) > 32'(total_reg))
                            begin
                                res_status_next = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_R_PN;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_BAD;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = res_id_reg;
                    out_count_next  = res_count_reg;
                    out_status_next = res_status_reg;
                    init_reply_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            S_P_RD:
            begin
                child_raddr = child_addr(cur_reg, item_sym);
                state_next  = S_P_CHK;
            end

            S_P_CHK:
            begin
                if (child_rdata != '0)
                begin
                    cur_next   = child_rdata;
                    state_next = S_P_LAST;
                end
                else if (32'(highest_reg) + 32'd1 >= MAX_NODES)
                begin
                    dropped_next    = 1'b1;
                    res_status_next = ST_FULL;
                    state_next      = S_P_LAST;
                end
                else
                begin
                    highest_next = highest_reg + 1'b1;
                    child_we     = 1'b1;
                    child_waddr  = child_addr(cur_reg, item_sym);
                    child_wdata  = highest_reg + 1'b1;
                    npat_we      = 1'b1;
                    npat_waddr   = highest_reg + 1'b1;
                    hit_we       = 1'b1;
                    hit_waddr    = highest_reg + 1'b1;
                    cur_next     = highest_reg + 1'b1;
                    idx_next     = '0;
                    state_next   = S_P_CLR;
                end
            end

            S_P_CLR:
            begin
                // A new node starts with an empty row of children.
                child_we    = 1'b1;
                child_waddr = child_addr(cur_reg, idx_sym);
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == SYM_IW'(ALPHABET - 1))
                begin
                    idx_next   = '0;
                    state_next = S_P_LAST;
                end
            end

            S_P_LAST:
            begin
                if (!item_reg.last)
                begin
                    state_next = S_DONE;
                end
                else if (dropped_reg)
                begin
                    dropped_next = 1'b0;
                    cur_next     = '0;
                    state_next   = S_DONE;
                end
                else
                begin
                    npat_raddr = cur_reg;
                    state_next = S_P_ID;
                end
            end

            S_P_ID:
            begin
                if (npat_rdata != '0)
                begin
                    res_id_next = npat_rdata;
                end
                else if (32'(total_reg) >= MAX_PATTERNS)
                begin
                    res_status_next = ST_NOID;
                end
                else
                begin
                    total_next  = total_reg + 1'b1;
                    res_id_next = total_reg + 1'b1;
                    npat_we     = 1'b1;
                    npat_waddr  = cur_reg;
                    npat_wdata  = total_reg + 1'b1;
                    pnode_we    = 1'b1;
                    pnode_waddr = PAT_AW'(total_reg);
                    pnode_wdata = cur_reg;
                end
                cur_next   = '0;
                state_next = S_DONE;
            end

            S_T_RD:
            begin
                child_raddr = child_addr(cur_reg, item_sym);
                state_next  = S_T_HIT;
            end

            S_T_HIT:
            begin
                cur_next   = child_rdata;
                hit_raddr  = child_rdata;
                state_next = S_T_WR;
            end

            S_T_WR:
            begin
                hit_we     = 1'b1;
                hit_waddr  = cur_reg;
                hit_wdata  = sat_add(hit_rdata, COUNT_BITS'(1));
                state_next = S_DONE;
            end

            S_B_ROOT_RD:
            begin
                child_raddr = child_addr('0, idx_sym);
                state_next  = S_B_ROOT_CHK;
            end

            S_B_ROOT_CHK:
            begin
                if (child_rdata != '0 && 32'(tail_reg) < MAX_NODES)
                begin
                    fail_we   = 1'b1;
                    fail_waddr = child_rdata;
                    bfs_we    = 1'b1;
                    bfs_waddr = tail_reg[NODE_W-1:0];
                    bfs_wdata = child_rdata;
                    tail_next = tail_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_B_ROOT_RD;
                if (idx_reg == SYM_IW'(ALPHABET - 1))
                begin
                    idx_next   = '0;
                    state_next = S_B_POP;
                end
            end

            S_B_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    bfs_raddr  = head_reg[NODE_W-1:0];
                    head_next  = head_reg + 1'b1;
                    state_next = S_B_FAIL;
                end
                else
                begin
                    phase_next = PH_SCAN;
                    state_next = S_DONE;
                end
            end

            S_B_FAIL:
            begin
                u_next     = bfs_rdata;
                fail_raddr = bfs_rdata;
                state_next = S_B_GETF;
            end

            S_B_GETF:
            begin
                f_next     = fail_rdata;
                idx_next   = '0;
                state_next = S_B_RDU;
            end

            S_B_RDU:
            begin
                child_raddr = child_addr(u_reg, idx_sym);
                state_next  = S_B_RDF;
            end

            S_B_RDF:
            begin
                v_next      = child_rdata;
                child_raddr = child_addr(f_reg, idx_sym);
                state_next  = S_B_WR;
            end

            S_B_WR:
            begin
                if (v_reg != '0)
                begin
                    fail_we    = 1'b1;
                    fail_waddr = v_reg;
                    fail_wdata = child_rdata;
                    if (32'(tail_reg) < MAX_NODES)
                    begin
                        bfs_we    = 1'b1;
                        bfs_waddr = tail_reg[NODE_W-1:0];
                        bfs_wdata = v_reg;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                else
                begin
                    // Missing transition takes the one of the failure target.
                    child_we    = 1'b1;
                    child_waddr = child_addr(u_reg, idx_sym);
                    child_wdata = child_rdata;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_B_RDU;
                if (idx_reg == SYM_IW'(ALPHABET - 1))
                begin
                    idx_next   = '0;
                    state_next = S_B_POP;
                end
            end

            S_A_BFS:
            begin
                if (k_reg == '0)
                begin
                    phase_next = PH_DONE;
                    state_next = S_DONE;
                end
                else
                begin
                    bfs_raddr  = k_reg - 1'b1;
                    k_next     = k_reg - 1'b1;
                    state_next = S_A_NODE;
                end
            end

            S_A_NODE:
            begin
                fail_raddr = bfs_rdata;
                hit_raddr  = bfs_rdata;
                state_next = S_A_TGT;
            end

            S_A_TGT:
            begin
                f_next     = fail_rdata;
                h_next     = hit_rdata;
                hit_raddr  = fail_rdata;
                state_next = S_A_WR;
            end

            S_A_WR:
            begin
                hit_we     = 1'b1;
                hit_waddr  = f_reg;
                hit_wdata  = sat_add(hit_rdata, h_reg);
                state_next = S_A_BFS;
            end

            S_R_PN:
            begin
                pnode_raddr = PAT_AW'(32'(item_reg.query_id) - 32'd1);
                state_next  = S_R_HIT;
            end

            S_R_HIT:
            begin
                hit_raddr  = pnode_rdata;
                state_next = S_R_OUT;
            end

            S_R_OUT:
            begin
                res_count_next = hit_rdata;
                res_id_next    = PIDS_W'(item_reg.query_id);
                state_next     = S_DONE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            phase_reg      <= PH_LOAD;
            highest_reg    <= '0;
            total_reg      <= '0;
            cur_reg        <= '0;
            dropped_reg    <= 1'b0;
            init_reply_reg <= 1'b0;
            idx_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            highest_reg    <= highest_next;
            total_reg      <= total_next;
            cur_reg        <= cur_next;
            dropped_reg    <= dropped_next;
            init_reply_reg <= init_reply_next;
            idx_reg        <= idx_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        u_reg          <= u_next;
        f_reg          <= f_next;
        v_reg          <= v_next;
        h_reg          <= h_next;
        res_id_reg     <= res_id_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        out_id_reg     <= out_id_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .raddr (child_raddr),
        .rdata (child_rdata)
    );

    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail_ram (
        .clk   (clk),
        .we    (fail_we),
        .waddr (fail_waddr),
        .wdata (fail_wdata),
        .raddr (fail_raddr),
        .rdata (fail_rdata)
    );

    mpmc_ram #(.WIDTH(PIDS_W), .DEPTH(MAX_NODES)) u_npat_ram (
        .clk   (clk),
        .we    (npat_we),
        .waddr (npat_waddr),
        .wdata (npat_wdata),
        .raddr (npat_raddr),
        .rdata (npat_rdata)
    );

    mpmc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_NODES)) u_hit_ram (
        .clk   (clk),
        .we    (hit_we),
        .waddr (hit_waddr),
        .wdata (hit_wdata),
        .raddr (hit_raddr),
        .rdata (hit_rdata)
    );

    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_bfs_ram (
        .clk   (clk),
        .we    (bfs_we),
        .waddr (bfs_waddr),
        .wdata (bfs_wdata),
        .raddr (bfs_raddr),
        .rdata (bfs_rdata)
    );

    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_PATTERNS)) u_pnode_ram (
        .clk   (clk),
        .we    (pnode_we),
        .waddr (pnode_waddr),
        .wdata (pnode_wdata),
        .raddr (pnode_raddr),
        .rdata (pnode_rdata)
    );

endmodule
`default_nettype wire

### rtl/multi_pattern_match_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-pattern match counter
// Aho-Corasick automaton that loads patterns, scans text and counts matches.
// ----------------------------------------------------------------------------
// Each input beat carries one command: clear, pattern symbol, build, text
// symbol, finish, or read count; every beat produces exactly one result beat.
// Beats enter a two-entry queue and are executed one at a time by a
// sequencer that owns the trie, failure link, id and count memories, all
// single read port RAMs with registered read data. A text symbol passes
// through dispatch, child table read, count read, count write and result
// hand-off, a chain of dependent memory reads. A pattern symbol that
// creates a node also clears the new node's child row, one entry per cycle.
// Build reads the root row, then visits each node in breadth-first order
// and reads each child of the node and of its failure target; finish adds
// each node's count into its failure target in reverse order. After reset,
// and on a clear command, the root row is swept before the next command is
// started. The result register lets the next command run while an earlier
// result is still stalled on the output.
// ----------------------------------------------------------------------------
module multi_pattern_match_counter
    import mpmc_pkg::*;
#(
    parameter int MAX_NODES    = 1024,
    parameter int MAX_PATTERNS = 255,
    parameter int ALPHABET     = 26,
    parameter int COUNT_BITS   = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [SYMBOL_W-1:0] symbol,
    input  wire logic                last,
    input  wire logic [QID_W-1:0]    query_id,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [PID_W-1:0]         pattern_id,
    output logic [MATCH_W-1:0]       match_count,
    output logic [STATUS_W-1:0]      status
);

    // Front end to queue.
    logic  push;
    item_t push_item;
    logic  q_full;

    // Queue to back end.
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    mpmc_front #(.ALPHABET(ALPHABET)) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .symbol   (symbol),
        .last     (last),
        .query_id (query_id),
        .q_full   (q_full),
        .q_push   (push),
        .q_item   (push_item)
    );

    mpmc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .item      (q_item)
    );

    mpmc_back #(
        .MAX_NODES    (MAX_NODES),
        .MAX_PATTERNS (MAX_PATTERNS),
        .ALPHABET     (ALPHABET),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pattern_id  (pattern_id),
        .match_count (match_count),
        .status      (status)
    );

endmodule
`default_nettype wire

### verif/multi_pattern_match_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-pattern match counter testbench
// Drives command beats into the automaton under random input gaps and output
// stalls. A behavioral trie mirrors the block and predicts every result beat,
// which a monitor compares field by field in order.
// ----------------------------------------------------------------------------
module multi_pattern_match_counter_tb;
    import mpmc_pkg::*;

    // These mirror the default parameters of the block.
    localparam int NODE_CAP  = 1024;
    localparam int ID_CAP    = 255;
    localparam int LETTERS   = 26;
    localparam logic [MATCH_W-1:0] COUNT_TOP = '1;

    typedef struct {
        logic [PID_W-1:0]    pid;
        logic [MATCH_W-1:0]  count;
        logic [STATUS_W-1:0] stat;
    } result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [MODE_W-1:0]   mode;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic [QID_W-1:0]    query_id;
    logic                out_valid;
    logic                out_stall;
    logic [PID_W-1:0]    pattern_id;
    logic [MATCH_W-1:0]  match_count;
    logic [STATUS_W-1:0] status;

    multi_pattern_match_counter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .symbol      (symbol),
        .last        (last),
        .query_id    (query_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pattern_id  (pattern_id),
        .match_count (match_count),
        .status      (status)
    );

    // 20 ns clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Behavioral copy of the automaton. The trie, failure links, breadth-first
    // order and per-node hit counters are kept exactly as the block keeps them.
    // ------------------------------------------------------------------------
    logic [9:0]         trie_next [0:NODE_CAP-1][0:LETTERS-1];
    logic [9:0]         fail_of   [0:NODE_CAP-1];
    logic [7:0]         id_at     [0:NODE_CAP-1];
    logic [MATCH_W-1:0] hits      [0:NODE_CAP-1];
    logic [9:0]         walk_seq  [0:NODE_CAP-1];
    logic [9:0]         node_of_id[0:ID_CAP-1];
    int                 node_top;
    int                 id_total;
    int                 cur_node;
    phase_t             ph;
    bit                 dropping;

    result_t expected_results[$];

    int beats_sent;
    int beats_checked;
    int mismatches;
    int burst_left;
    int reads_done;

    function automatic logic [MATCH_W-1:0] bump(logic [MATCH_W-1:0] a,
                                                logic [MATCH_W-1:0] b);
        logic [MATCH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[MATCH_W] ? COUNT_TOP : s[MATCH_W-1:0];
    endfunction

    function automatic void trie_clear();
        for (int n = 0; n < NODE_CAP; n++)
        begin
            for (int a = 0; a < LETTERS; a++)
                trie_next[n][a] = '0;
            fail_of[n]  = '0;
            id_at[n]    = '0;
            hits[n]     = '0;
            walk_seq[n] = '0;
        end
        for (int i = 0; i < ID_CAP; i++)
            node_of_id[i] = '0;
        node_top = 0;
        id_total = 0;
        cur_node = 0;
        ph       = PH_LOAD;
        dropping = 1'b0;
    endfunction

    // One pattern symbol: walk or grow the trie, hand out an id at the end.
    function automatic void trie_insert(int sym, bit lst, inout result_t r);
        int nxt;
        int id;
        if (dropping)
            r.stat = ST_FULL;
        else
        begin
            nxt = trie_next[cur_node][sym];
            if (nxt == 0)
            begin
                if (node_top + 1 >= NODE_CAP)
                begin
                    dropping = 1'b1;
                    r.stat   = ST_FULL;
                end
                else
                begin
                    node_top++;
                    nxt = node_top;
                    for (int a = 0; a < LETTERS; a++)
                        trie_next[nxt][a] = '0;
                    fail_of[nxt] = '0;
                    id_at[nxt]   = '0;
                    hits[nxt]    = '0;
                    trie_next[cur_node][sym] = 10'(nxt);
                end
            end
            if (!dropping)
                cur_node = nxt;
        end
        if (lst)
        begin
            if (!dropping)
            begin
                id = id_at[cur_node];
                if (id == 0)
                begin
                    if (id_total >= ID_CAP)
                        r.stat = ST_NOID;
                    else
                    begin
                        id_total++;
                        id = id_total;
                        id_at[cur_node] = 8'(id);
                        node_of_id[id-1] = 10'(cur_node);
                    end
                end
                r.pid = PID_W'(id);
            end
            dropping = 1'b0;
            cur_node = 0;
        end
    endfunction

    // Breadth-first pass that fills failure links and missing transitions.
    function automatic void trie_link();
        int head;
        int tail;
        int u;
        int f;
        int v;
        head = 0;
        tail = 0;
        for (int a = 0; a < LETTERS; a++)
        begin
            v = trie_next[0][a];
            if (v != 0 && tail < NODE_CAP)
            begin
                fail_of[v] = '0;
                walk_seq[tail++] = 10'(v);
            end
        end
        while (head < tail)
        begin
            u = walk_seq[head++];
            f = fail_of[u];
            for (int a = 0; a < LETTERS; a++)
            begin
                v = trie_next[u][a];
                if (v != 0)
                begin
                    fail_of[v] = trie_next[f][a];
                    if (tail < NODE_CAP)
                        walk_seq[tail++] = 10'(v);
                end
                else
                    trie_next[u][a] = trie_next[f][a];
            end
        end
    endfunction

    function automatic result_t predict_result(logic [MODE_W-1:0] md,
                                               logic [SYMBOL_W-1:0] sym,
                                               logic lst,
                                               logic [QID_W-1:0] qid);
        result_t r;
        int n;
        r.pid   = '0;
        r.count = '0;
        r.stat  = ST_OK;
        case (md)
            MODE_CLEAR:
                trie_clear();
            MODE_PATTERN:
                if (ph != PH_LOAD || sym >= LETTERS)
                    r.stat = ST_BAD;
                else
                    trie_insert(sym, lst, r);
            MODE_BUILD:
                if (ph != PH_LOAD)
                    r.stat = ST_BAD;
                else
                begin
                    cur_node = 0;
                    dropping = 1'b0;
                    trie_link();
                    ph = PH_SCAN;
                end
            MODE_TEXT:
                if (ph != PH_SCAN || sym >= LETTERS)
                    r.stat = ST_BAD;
                else
                begin
                    cur_node = trie_next[cur_node][sym];
                    hits[cur_node] = bump(hits[cur_node], MATCH_W'(1));
                end
            MODE_FINISH:
                if (ph != PH_SCAN)
                    r.stat = ST_BAD;
                else
                begin
                    // Reverse breadth-first order pushes counts up the fail tree toward the root.
                    for (int k = node_top; k > 0; k--)
                    begin
                        n = walk_seq[k-1];
                        hits[fail_of[n]] = bump(hits[fail_of[n]], hits[n]);
                    end
                    ph = PH_DONE;
                end
            MODE_READ:
                if (ph != PH_DONE || qid == 0 || qid > id_total)
                    r.stat = ST_BAD;
                else
                begin
                    r.pid   = qid;
                    r.count = hits[node_of_id[qid-1]];
                end
            default:
                r.stat = ST_BAD;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Beats go out in bursts of random length; between bursts valid
    // drops for a random gap. Within a burst valid stays high, so only the
    // payload changes on the falling edge after each accepted beat.
    // ------------------------------------------------------------------------
    task automatic send_beat(logic [MODE_W-1:0] md, logic [SYMBOL_W-1:0] sym,
                             logic lst, logic [QID_W-1:0] qid);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            // One burst in four is long, so stretches with no gaps occur too.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        mode     <= md;
        symbol   <= sym;
        last     <= lst;
        query_id <= qid;
        @(posedge clk);
        while (!(in_valid && !in_stall))
            @(posedge clk);
        burst_left--;
        beats_sent++;
        expected_results.insert(expected_results.size(),
                                predict_result(md, sym, lst, qid));
        @(negedge clk);
    endtask

    task automatic send_word(string w);
        for (int i = 0; i < w.len(); i++)
            send_beat(MODE_PATTERN, SYMBOL_W'(w[i] - "a"), i == w.len() - 1, '0);
    endtask

    task automatic send_text(string w);
        for (int i = 0; i < w.len(); i++)
            send_beat(MODE_TEXT, SYMBOL_W'(w[i] - "a"), 1'b0, '0);
    endtask

    task automatic send_random_word(int len, int span);
        for (int i = 0; i < len; i++)
            send_beat(MODE_PATTERN, SYMBOL_W'($urandom_range(0, span - 1)),
                      i == len - 1, QID_W'($urandom));
    endtask

    // Read back every assigned id, then ids 0, total + 1 and 255, rejected unless assigned.
    task automatic read_all_ids();
        int total;
        total = id_total;
        for (int q = 1; q <= total; q++)
        begin
            send_beat(MODE_READ, SYMBOL_W'($urandom), 1'($urandom), QID_W'(q));
            reads_done++;
        end
        send_beat(MODE_READ, '0, 1'b0, '0);
        send_beat(MODE_READ, '0, 1'b0, QID_W'(total + 1));
        send_beat(MODE_READ, '0, 1'b0, 8'hFF);
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall pattern: every so often a new style is chosen, from no
    // stall at all to heavy random stalls or a fixed duty cycle.
    // ------------------------------------------------------------------------
    int stall_style;
    int stall_left;
    int stall_tick;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_style <= 0;
            stall_left  <= 0;
            stall_tick  <= 0;
        end
        else
        begin
            stall_tick <= stall_tick + 1;
            if (stall_left == 0)
            begin
                stall_style <= $urandom_range(0, 3);
                stall_left  <= $urandom_range(20, 200);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_style)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= (stall_tick % 3 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: each accepted result beat is matched against the oldest
    // prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat with nothing expected: id=%0d count=%0d st=%0d",
                             pattern_id, match_count, status);
            end
            else
            begin
                want = expected_results.pop_front();
                beats_checked++;
                if (pattern_id !== want.pid || match_count !== want.count ||
                    status !== want.stat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: beat %0d: got id=%0d count=%0d st=%0d, want id=%0d count=%0d st=%0d",
                                 beats_checked, pattern_id, match_count, status,
                                 want.pid, want.count, want.stat);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // The classic he/she/his/hers example plus several illegal orderings.
    task automatic test_directed();
        send_beat(MODE_TEXT, 5'd0, 1'b0, '0);     // text while loading
        send_beat(MODE_FINISH, '0, 1'b0, '0);     // finish while loading
        send_beat(MODE_READ, '0, 1'b0, 8'd1);     // read while loading
        send_beat(3'd6, 5'd31, 1'b1, 8'hAA);      // unused modes
        send_beat(3'd7, 5'd0, 1'b0, 8'h55);
        send_beat(MODE_PATTERN, 5'd26, 1'b1, '0); // letters past z
        send_beat(MODE_PATTERN, 5'd31, 1'b0, '0);
        send_word("he");
        send_word("she");
        send_word("his");
        send_word("hers");
        send_word("he");                          // duplicate shares its id
        send_beat(MODE_PATTERN, 5'd25, 1'b0, '0); // unfinished path at build
        send_beat(MODE_BUILD, '0, 1'b0, '0);
        send_beat(MODE_BUILD, '0, 1'b0, '0);      // second build is out of order
        send_beat(MODE_PATTERN, 5'd0, 1'b1, '0);
        send_text("ushers");
        send_beat(MODE_TEXT, 5'd31, 1'b0, '0);
        send_beat(MODE_FINISH, '0, 1'b0, '0);
        send_beat(MODE_TEXT, 5'd1, 1'b0, '0);     // text after finish
        read_all_ids();
    endtask

    // Fill the node store with long patterns until it overflows.
    task automatic test_node_store_full();
        send_beat(MODE_CLEAR, '0, 1'b0, '0);
        while (node_top < NODE_CAP - 1)
            send_random_word(30, LETTERS);
        send_random_word(12, LETTERS);            // dropped once a new node is needed: status full from there on
        send_random_word(5, LETTERS);
        send_word("a");                           // existing node still gets an id
        send_beat(MODE_BUILD, '0, 1'b0, '0);
        for (int i = 0; i < 60; i++)
            send_beat(MODE_TEXT, SYMBOL_W'($urandom_range(0, LETTERS - 1)), 1'b0, '0);
        send_beat(MODE_FINISH, '0, 1'b0, '0);
        read_all_ids();
    endtask

    // More distinct patterns than there are ids; two-letter words keep the trie small.
    task automatic test_ids_exhausted();
        send_beat(MODE_CLEAR, '0, 1'b0, '0);
        for (int w = 0; w < ID_CAP + 5; w++)
        begin
            send_beat(MODE_PATTERN, SYMBOL_W'(w / LETTERS), 1'b0, '0);
            send_beat(MODE_PATTERN, SYMBOL_W'(w % LETTERS), 1'b1, '0);
        end
        send_beat(MODE_PATTERN, 5'd0, 1'b0, '0);  // duplicate of id 1 still allowed
        send_beat(MODE_PATTERN, 5'd0, 1'b1, '0);
        send_beat(MODE_BUILD, '0, 1'b0, '0);
        for (int i = 0; i < 80; i++)
            send_beat(MODE_TEXT, SYMBOL_W'($urandom_range(0, 11)), 1'b0, '0);
        send_beat(MODE_FINISH, '0, 1'b0, '0);
        read_all_ids();
    endtask

    // Complete load/build/scan/finish/read rounds with random content. Small
    // alphabets make overlaps and repeated matches common.
    task automatic test_random_rounds(int target);
        int stop_at;
        int span;
        stop_at = beats_sent + target;
        while (beats_sent < stop_at)
        begin
            send_beat(MODE_CLEAR, $urandom, $urandom, $urandom);
            span = ($urandom_range(0, 3) == 0) ? LETTERS : $urandom_range(2, 5);
            repeat ($urandom_range(1, 12))
            begin
                send_random_word($urandom_range(1, 5), span);
                // Occasional noise: illegal letters, wrong phases, unused modes.
                if ($urandom_range(0, 9) == 0)
                    send_beat($urandom_range(0, 7) == 0 ? 3'd6 + $urandom_range(0, 1)
                                                        : MODE_READ,
                              $urandom, $urandom, $urandom);
                if ($urandom_range(0, 9) == 0)
                    send_beat(MODE_PATTERN, $urandom_range(26, 31), $urandom, '0);
            end
            if ($urandom_range(0, 4) == 0)
                send_beat(MODE_PATTERN, $urandom_range(0, span - 1), 1'b0, '0);
            send_beat(MODE_BUILD, $urandom, $urandom, $urandom);
            repeat ($urandom_range(20, 150))
            begin
                if ($urandom_range(0, 49) == 0)
                    send_beat(MODE_TEXT, $urandom_range(26, 31), 1'b0, '0);
                else
                    send_beat(MODE_TEXT, $urandom_range(0, span - 1), $urandom,
                              $urandom);
            end
            send_beat(MODE_FINISH, $urandom, $urandom, $urandom);
            read_all_ids();
            repeat ($urandom_range(0, 3))
                send_beat(MODE_READ, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_CLEAR;
        symbol     = '0;
        last       = 1'b0;
        query_id   = '0;
        beats_sent = 0;
        beats_checked = 0;
        mismatches = 0;
        burst_left = 0;
        reads_done = 0;
        trie_clear();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_node_store_full();
        test_ids_exhausted();
        test_random_rounds(1000);

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d command beats and checked %0d results, %0d of them count reads,",
                 beats_sent, beats_checked, reads_done);
        $display("covering node store overflow, id exhaustion and illegal orderings; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Generous bound: the full-store build and finish dominate the run.
    initial
    begin
        #40_000_000;
        $display("ERROR: timeout with %0d results outstanding", expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
rtl/mpmc_pkg.sv
rtl/mpmc_ram.sv
rtl/mpmc_front.sv
rtl/mpmc_queue.sv
rtl/mpmc_back.sv
rtl/multi_pattern_match_counter.sv
verif/multi_pattern_match_counter_tb.sv
